/* sv/cpc_pkg.sv */
// Contact position correction: shared constants, status codes, stage record.
// Used by contact_position_correction_top. No dependencies.
package cpc_pkg;

  localparam int NSQ  = 32;  // root bits, one per stage
  localparam int NDIV = 31;  // quotient bits, one per stage

  localparam logic [1:0]  REG_SLOP = 2'd0;
  localparam logic [1:0]  REG_PCT  = 2'd1;
  localparam logic [15:0] SLOP_RST = 16'd655;
  localparam logic [16:0] PCT_RST  = 17'd52429;

  localparam int FLAG_STATIC = 0;
  localparam int FLAG_TRIG   = 1;
  localparam int FLAG_NOBODY = 2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRIG    = 3'd1,
    ST_SHALLOW = 3'd2,
    ST_ZNORM   = 3'd3,
    ST_ZMASS   = 3'd4
  } status_t;

  typedef struct packed {
    status_t            status;
    logic               keep_a;
    logic               keep_b;
    logic               xneg;
    logic               yneg;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [30:0]        d;
    logic [31:0]        m;
    logic [30:0]        inva;
    logic [30:0]        invb;
    logic [31:0]        sum;
    logic signed [64:0] px;
    logic signed [64:0] py;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [63:0]        sv;
    logic [63:0]        sr;
    logic [61:0]        rem_a;
    logic [61:0]        rem_b;
    logic [30:0]        wa;
    logic [30:0]        wb;
    logic [31:0]        root;
    logic [61:0]        rem_x;
    logic [61:0]        rem_y;
    logic [30:0]        ux;
    logic [30:0]        uy;
    logic [31:0]        ta;
    logic [31:0]        tb;
  } item_t;

  // sign and saturate a magnitude to 32-bit two's complement
  function automatic logic [31:0] emit(input logic [32:0] mag, input logic neg);
    logic [32:0] lim;
    begin
      if (neg) begin
        lim = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;
        emit = 32'(33'h1_0000_0000 - lim);
      end else begin
        emit = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
    end
  endfunction

endpackage

/* sv/contact_position_correction_top.sv */
// Contact position correction pipeline, top level.
// Depends on cpc_pkg (types, status codes, saturation helper).
//
// Usage:
//   Input words carry one contact (normal, depth, centers, inverse masses,
//   flags) on a valid/ready channel; each yields exactly one output word with
//   four saturated Q16.16 shift deltas and a status code.
//   Stages in order: 4 setup stages, a 32-stage bit-per-stage square
//   root (inverse-mass dividers run alongside), one divider setup stage, a
//   31-stage bit-per-stage normal divider, one multiply stage and the output
//   register. Throughput is one word per cycle while out_ready does not
//   stall the pipeline; every stage holds one contact.
//   When the receiver holds out_ready low with a word pending, the whole
//   pipeline freezes and in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads slop_depth = 655 and
//   correction_percent = 52429. Registers are written through cfg_we,
//   cfg_index and cfg_data; indexes beyond the two registers are ignored.
module contact_position_correction_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] penetration,
  input  logic signed [31:0] center_a_x,
  input  logic signed [31:0] center_a_y,
  input  logic signed [31:0] center_b_x,
  input  logic signed [31:0] center_b_y,
  input  logic [30:0]        inv_mass_a,
  input  logic [30:0]        inv_mass_b,
  input  logic [2:0]         flags_a,
  input  logic [2:0]         flags_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] shift_a_x,
  output logic signed [31:0] shift_a_y,
  output logic signed [31:0] shift_b_x,
  output logic signed [31:0] shift_b_y,
  output logic [2:0]         status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import cpc_pkg::*;

  logic [15:0] slop_depth;
  logic [16:0] correction_percent;
  logic        en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      slop_depth         <= SLOP_RST;
      correction_percent <= PCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOP: slop_depth         <= cfg_data[15:0];
        REG_PCT:  correction_percent <= cfg_data;
        default:  ;
      endcase
    end
  end

  // stage 0: classify, magnitudes, center difference
  item_t p0, p0_next;
  logic  v0;

  always_comb begin
    logic signed [32:0] dep;
    logic               trig;
    p0_next = '0;
    trig = flags_a[FLAG_TRIG] || flags_b[FLAG_TRIG] ||
           (flags_a[FLAG_STATIC] && flags_b[FLAG_STATIC]);
    dep = {penetration[31], penetration} - $signed({17'd0, slop_depth});
    p0_next.sum = {1'b0, inv_mass_a} + {1'b0, inv_mass_b};
    if (trig)                                  p0_next.status = ST_TRIG;
    else if (penetration <= 0)                 p0_next.status = ST_SHALLOW;
    else if (normal_x == 0 && normal_y == 0)   p0_next.status = ST_ZNORM;
    else if (dep <= 0)                         p0_next.status = ST_SHALLOW;
    else if (p0_next.sum == 32'd0)             p0_next.status = ST_ZMASS;
    else                                       p0_next.status = ST_OK;
    p0_next.keep_a = !flags_a[FLAG_STATIC] && !flags_a[FLAG_NOBODY];
    p0_next.keep_b = !flags_b[FLAG_STATIC] && !flags_b[FLAG_NOBODY];
    p0_next.xneg   = normal_x[31];
    p0_next.yneg   = normal_y[31];
    p0_next.nx     = normal_x;
    p0_next.ny     = normal_y;
    p0_next.dx     = {center_b_x[31], center_b_x} - {center_a_x[31], center_a_x};
    p0_next.dy     = {center_b_y[31], center_b_y} - {center_a_y[31], center_a_y};
    p0_next.ax     = normal_x[31] ? (~normal_x + 32'd1) : normal_x;
    p0_next.ay     = normal_y[31] ? (~normal_y + 32'd1) : normal_y;
    p0_next.d      = dep[30:0];
    p0_next.inva   = inv_mass_a;
    p0_next.invb   = inv_mass_b;
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
    if (en) p0 <= p0_next;
  end

  // stage 1: normalize, dot products, scaled depth
  item_t p1, p1_next;
  logic  v1;

  always_comb begin
    logic [31:0] o;
    logic [4:0]  msb;
    logic [4:0]  sh;
    logic [47:0] prod;
    p1_next = p0;
    o   = p0.ax | p0.ay;
    msb = 5'd30;
    for (int i = 0; i < 32; i++) begin
      if (o[i]) msb = 5'(i);
    end
    sh = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
    p1_next.ax = p0.ax << sh;
    p1_next.ay = p0.ay << sh;
    p1_next.px = p0.dx * p0.nx;
    p1_next.py = p0.dy * p0.ny;
    prod = p0.d * correction_percent;
    p1_next.m  = prod[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) p1 <= p1_next;
  end

  // stage 2: squares, direction flip
  item_t p2, p2_next;
  logic  v2;

  always_comb begin
    logic signed [65:0] dot;
    p2_next = p1;
    dot = p1.px + p1.py;
    p2_next.xneg = p1.xneg ^ dot[65];
    p2_next.yneg = p1.yneg ^ dot[65];
    p2_next.sqx  = p1.ax * p1.ax;
    p2_next.sqy  = p1.ay * p1.ay;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) p2 <= p2_next;
  end

  // stage 3: radicand, iteration setup
  item_t p3, p3_next;
  logic  v3;

  always_comb begin
    p3_next = p2;
    p3_next.sv    = p2.sqx + p2.sqy;
    p3_next.sr    = 64'd0;
    p3_next.rem_a = {p2.inva, 31'd0} >> 1;
    p3_next.rem_b = {p2.invb, 31'd0} >> 1;
    p3_next.wa    = 31'd0;
    p3_next.wb    = 31'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) p3 <= p3_next;
  end

  // square root, one bit per stage; mass weights divided alongside
  item_t sq  [0:NSQ];
  logic  sqv [0:NSQ];

  assign sq[0]  = p3;
  assign sqv[0] = v3;

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    localparam int QB = (k < NDIV) ? NDIV - 1 - k : 0;
    item_t nxt;

    always_comb begin
      logic [63:0] trial;
      logic [62:0] dsh;
      nxt   = sq[k];
      trial = sq[k].sr + BIT;
      dsh   = {31'd0, sq[k].sum} << QB;
      if (sq[k].sv >= trial) begin
        nxt.sv = sq[k].sv - trial;
        nxt.sr = (sq[k].sr >> 1) + BIT;
      end else begin
        nxt.sr = sq[k].sr >> 1;
      end
      if (k < NDIV) begin
        if ({1'b0, sq[k].rem_a} >= dsh) begin
          nxt.rem_a  = sq[k].rem_a - dsh[61:0];
          nxt.wa[QB] = 1'b1;
        end
        if ({1'b0, sq[k].rem_b} >= dsh) begin
          nxt.rem_b  = sq[k].rem_b - dsh[61:0];
          nxt.wb[QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sqv[k+1] <= 1'b0;
      else if (en) sqv[k+1] <= sqv[k];
      if (en) sq[k+1] <= nxt;
    end
  end

  // normal divider setup, per-body scaled depth
  item_t pu, pu_next;
  logic  vu;

  always_comb begin
    logic [62:0] pa;
    logic [62:0] pb;
    pu_next = sq[NSQ];
    pu_next.root  = sq[NSQ].sr[31:0];
    pu_next.rem_x = {sq[NSQ].ax, 30'd0};
    pu_next.rem_y = {sq[NSQ].ay, 30'd0};
    pu_next.ux    = 31'd0;
    pu_next.uy    = 31'd0;
    pa = sq[NSQ].m * sq[NSQ].wa;
    pb = sq[NSQ].m * sq[NSQ].wb;
    pu_next.ta = pa[61:30];
    pu_next.tb = pb[61:30];
  end

  always_ff @(posedge clk) begin
    if (rst) vu <= 1'b0;
    else if (en) vu <= sqv[NSQ];
    if (en) pu <= pu_next;
  end

  // unit normal division, one quotient bit per stage
  item_t dv  [0:NDIV];
  logic  dvv [0:NDIV];

  assign dv[0]  = pu;
  assign dvv[0] = vu;

  for (genvar k = 0; k < NDIV; k++) begin : g_dv
    item_t nxt;

    always_comb begin
      logic [62:0] dsh;
      nxt = dv[k];
      dsh = {31'd0, dv[k].root} << (NDIV - 1 - k);
      if ({1'b0, dv[k].rem_x} >= dsh) begin
        nxt.rem_x = dv[k].rem_x - dsh[61:0];
        nxt.ux[NDIV - 1 - k] = 1'b1;
      end
      if ({1'b0, dv[k].rem_y} >= dsh) begin
        nxt.rem_y = dv[k].rem_y - dsh[61:0];
        nxt.uy[NDIV - 1 - k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dvv[k+1] <= 1'b0;
      else if (en) dvv[k+1] <= dvv[k];
      if (en) dv[k+1] <= nxt;
    end
  end

  // final products
  localparam logic [30:0] U_ONE = 31'h4000_0000;

  logic [32:0] mag_ax, mag_ay, mag_bx, mag_by;
  logic        vm, m_ok_a, m_ok_b, m_xneg, m_yneg;
  status_t     m_status;

  always_ff @(posedge clk) begin
    logic [30:0] uxc;
    logic [30:0] uyc;
    logic [62:0] qax, qay, qbx, qby;
    uxc = (dv[NDIV].ux > U_ONE) ? U_ONE : dv[NDIV].ux;
    uyc = (dv[NDIV].uy > U_ONE) ? U_ONE : dv[NDIV].uy;
    qax = dv[NDIV].ta * uxc;
    qay = dv[NDIV].ta * uyc;
    qbx = dv[NDIV].tb * uxc;
    qby = dv[NDIV].tb * uyc;
    if (rst) vm <= 1'b0;
    else if (en) vm <= dvv[NDIV];
    if (en) begin
      mag_ax   <= qax[62:30];
      mag_ay   <= qay[62:30];
      mag_bx   <= qbx[62:30];
      mag_by   <= qby[62:30];
      m_status <= dv[NDIV].status;
      m_ok_a   <= (dv[NDIV].status == ST_OK) && dv[NDIV].keep_a;
      m_ok_b   <= (dv[NDIV].status == ST_OK) && dv[NDIV].keep_b;
      m_xneg   <= dv[NDIV].xneg;
      m_yneg   <= dv[NDIV].yneg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vm;
    if (en) begin
      shift_a_x <= m_ok_a ? emit(mag_ax, !m_xneg) : 32'd0;
      shift_a_y <= m_ok_a ? emit(mag_ay, !m_yneg) : 32'd0;
      shift_b_x <= m_ok_b ? emit(mag_bx, m_xneg) : 32'd0;
      shift_b_y <= m_ok_b ? emit(mag_by, m_yneg) : 32'd0;
      status    <= m_status;
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking bench for contact_position_correction_top: random and directed
// contacts, bit-exact fixed-point prediction, valid/ready pacing on both sides.
// Depends on cpc_pkg and the RTL top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpc_pkg::*;

  typedef struct {
    logic [31:0] nx, ny, pen, cax, cay, cbx, cby;
    logic [30:0] ia, ib;
    logic [2:0]  fa, fb;
  } contact_t;

  typedef struct {
    logic [31:0] sax, say, sbx, sby;
    status_t     st;
  } shift_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_we = 0;
  logic [1:0] cfg_index = REG_SLOP;
  logic [16:0] cfg_data = 0;
  logic signed [31:0] normal_x = 0, normal_y = 0, penetration = 0;
  logic signed [31:0] center_a_x = 0, center_a_y = 0, center_b_x = 0, center_b_y = 0;
  logic [30:0] inv_mass_a = 0, inv_mass_b = 0;
  logic [2:0] flags_a = 0, flags_b = 0;
  logic in_ready, out_valid;
  logic signed [31:0] shift_a_x, shift_a_y, shift_b_x, shift_b_y;
  logic [2:0] status;

  contact_position_correction_top dut (.*);

  always #5 clk = ~clk;

  contact_t pending_q[$];
  shift_t   expected_q[$];
  logic [15:0] slop = SLOP_RST;
  logic [16:0] pct = PCT_RST;
  int errors = 0, idle_cycles = 0, burst = 0, gap = 0;
  int stall_mode = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] sat(input logic [63:0] mag, input logic neg);
    if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'h1_0000_0000 - mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic shift_t correct_contact(input contact_t c);
    shift_t s;
    longint nx, ny, pen, dx, dy;
    logic [63:0] ax, ay, ux, uy, d, m, sum, w, t, r;
    logic [127:0] p, q;
    logic xneg, yneg, pn, qn, flip;
    nx = longint'($signed(c.nx)); ny = longint'($signed(c.ny));
    pen = longint'($signed(c.pen));
    dx = longint'($signed(c.cbx)) - longint'($signed(c.cax));
    dy = longint'($signed(c.cby)) - longint'($signed(c.cay));
    s = '{0, 0, 0, 0, ST_OK};
    sum = 64'(c.ia) + 64'(c.ib);
    if (c.fa[FLAG_TRIG] || c.fb[FLAG_TRIG] || (c.fa[FLAG_STATIC] && c.fb[FLAG_STATIC]))
      s.st = ST_TRIG;
    else if (pen <= 0) s.st = ST_SHALLOW;
    else if (nx == 0 && ny == 0) s.st = ST_ZNORM;
    else if (pen - longint'(slop) <= 0) s.st = ST_SHALLOW;
    else if (sum == 0) s.st = ST_ZMASS;
    if (s.st != ST_OK) return s;
    ax = nx < 0 ? -nx : nx; ay = ny < 0 ? -ny : ny;
    xneg = nx < 0; yneg = ny < 0;
    while (ax < (64'd1 << 30) && ay < (64'd1 << 30)) begin
      ax <<= 1; ay <<= 1;
    end
    r = 64'(isqrt(ax * ax + ay * ay));
    ux = (ax << 30) / r; if (ux > (64'd1 << 30)) ux = 64'd1 << 30;
    uy = (ay << 30) / r; if (uy > (64'd1 << 30)) uy = 64'd1 << 30;
    p = 128'(dx < 0 ? -dx : dx) * 128'(nx < 0 ? -nx : nx);
    q = 128'(dy < 0 ? -dy : dy) * 128'(ny < 0 ? -ny : ny);
    pn = p != 0 && ((dx < 0) != (nx < 0));
    qn = q != 0 && ((dy < 0) != (ny < 0));
    if (pn == qn) flip = pn;
    else if (pn) flip = p > q;
    else flip = q > p;
    if (flip) begin
      xneg = !xneg; yneg = !yneg;
    end
    d = 64'(pen - longint'(slop));
    m = (d * 64'(pct)) >> 16;
    if (!c.fa[FLAG_STATIC] && !c.fa[FLAG_NOBODY]) begin
      w = (64'(c.ia) << 30) / sum;
      t = (m * w) >> 30;
      s.sax = sat((t * ux) >> 30, !xneg);
      s.say = sat((t * uy) >> 30, !yneg);
    end
    if (!c.fb[FLAG_STATIC] && !c.fb[FLAG_NOBODY]) begin
      w = (64'(c.ib) << 30) / sum;
      t = (m * w) >> 30;
      s.sbx = sat((t * ux) >> 30, xneg);
      s.sby = sat((t * uy) >> 30, yneg);
    end
    return s;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic contact_t rnd_contact();
    contact_t c;
    c.nx = rnd32(); c.ny = rnd32();
    c.pen = ($urandom_range(0, 4) != 0) ? 32'($urandom_range(1, 32'h0010_0000)) : rnd32();
    if ($urandom_range(0, 7) == 0) c.pen = $urandom;
    c.cax = rnd32(); c.cay = rnd32(); c.cbx = rnd32(); c.cby = rnd32();
    c.ia = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
    c.ib = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
    c.fa = ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'd0;
    c.fb = ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'd0;
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(correct_contact(pending_q.pop_front()));
      end
      if (!(in_valid && !in_ready)) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if (pending_q.size() > 0 && !(in_valid && in_ready && pending_q.size() == 0)) begin
          normal_x <= pending_q[0].nx; normal_y <= pending_q[0].ny;
          penetration <= pending_q[0].pen;
          center_a_x <= pending_q[0].cax; center_a_y <= pending_q[0].cay;
          center_b_x <= pending_q[0].cbx; center_b_y <= pending_q[0].cby;
          inv_mass_a <= pending_q[0].ia; inv_mass_b <= pending_q[0].ib;
          flags_a <= pending_q[0].fa; flags_b <= pending_q[0].fb;
          in_valid <= 1;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    shift_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected output word");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (shift_a_x !== e.sax) report("shift_a_x", shift_a_x, e.sax);
          if (shift_a_y !== e.say) report("shift_a_y", shift_a_y, e.say);
          if (shift_b_x !== e.sbx) report("shift_b_x", shift_b_x, e.sbx);
          if (shift_b_y !== e.sby) report("shift_b_y", shift_b_y, e.sby);
          if (status !== e.st) report("status", 32'(status), 32'(e.st));
        end
      end
      case (stall_mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else if (pending_q.size() > 0 || expected_q.size() > 0) idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_SLOP) slop = val[15:0];
    else if (idx == REG_PCT) pct = val;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic add(input logic [31:0] nx, ny, pen, cax, cay, cbx, cby,
                     input logic [30:0] ia, ib, input logic [2:0] fa, fb);
    contact_t c;
    c = '{nx, ny, pen, cax, cay, cbx, cby, ia, ib, fa, fb};
    pending_q.push_back(c);
  endtask

  initial begin
    logic [16:0] slops[4], pcts[4];
    slops = '{17'd0, 17'd65535, 17'd655, 17'd1234};
    pcts = '{17'd65536, 17'd0, 17'd52429, 17'd30000};
    repeat (3) @(posedge clk);
    rst <= 0;
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 0, 31'h1_0000, 31'h1_0000, 0, 0);
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 32'hFFFF_0000, 0, 31'h1_0000, 31'h1_0000, 0, 0);
    add(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h1, 0, 0);
    add(32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 31'h1, 31'h7FFF_FFFF, 0, 0);
    add(32'h1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0);
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 0, 0, 1, 1, 3'b010, 0);
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 0, 0, 1, 1, 0, 3'b010);
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 0, 0, 1, 1, 3'b001, 3'b001);
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 0, 0, 1, 1, 3'b001, 0);
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 0, 0, 1, 1, 0, 3'b100);
    add(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 0, 0, 1, 1, 3'b100, 3'b101);
    add(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
    add(32'h0001_0000, 0, 32'h8000_0000, 0, 0, 0, 0, 1, 1, 0, 0);
    add(0, 0, 32'h0002_0000, 0, 0, 0, 0, 1, 1, 0, 0);
    add(32'h0001_0000, 0, 32'd655, 0, 0, 0, 0, 1, 1, 0, 0);
    add(32'h0001_0000, 0, 32'd656, 0, 0, 0, 0, 1, 1, 0, 0);
    add(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    add(32'hFFFF_0000, 32'h0003_0000, 32'h0005_0000, 5, 5, 5, 5, 0, 31'h7FFF_FFFF, 0, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_SLOP, slops[ph]);
      write_reg(REG_PCT, pcts[ph]);
      write_reg(2'd3, 17'h1FFFF);
      for (int i = 0; i < 125; i++) pending_q.push_back(rnd_contact());
      drain();
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
